// ===== rtl/tmbas_pkg.sv =====
// shared types, codes and the control-write table of the bus arbitration sequencer
package tmbas_pkg;

    localparam int TICK_W = 24;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // configuration register indexes
    localparam logic [1:0] CFG_FORCE_AFTER   = 2'd0;
    localparam logic [1:0] CFG_GIVE_UP_AFTER = 2'd1;
    localparam logic [1:0] CFG_SHORT_RETRY   = 2'd2;
    localparam logic [1:0] CFG_LONG_RETRY    = 2'd3;

    localparam logic [TICK_W-1:0] FORCE_AFTER_RST   = 24'd125000;
    localparam logic [TICK_W-1:0] GIVE_UP_AFTER_RST = 24'd250000;
    localparam logic [TICK_W-1:0] SHORT_RETRY_RST   = 24'd50;
    localparam logic [TICK_W-1:0] LONG_RETRY_RST    = 24'd1000;

    // commands
    localparam logic [1:0] CMD_ACQUIRE  = 2'd0;
    localparam logic [1:0] CMD_RELEASE  = 2'd1;
    localparam logic [1:0] CMD_COMPLETE = 2'd2;
    localparam logic [1:0] CMD_TICK     = 2'd3;

    // actions
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_DONE  = 2'd2;

    // completion status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_XFER    = 2'd2;

    // selector registers
    localparam logic [1:0] REG_NONE    = 2'd0;
    localparam logic [1:0] REG_CONTROL = 2'd1;
    localparam logic [1:0] REG_ISTAT   = 2'd2;

    localparam logic [7:0] CTL_NBUSON  = 8'h08;
    localparam logic [7:0] CTL_BUSINIT = 8'h10;
    localparam logic [7:0] CTL_NTESTON = 8'h80;

    // phases
    localparam logic [3:0] PH_IDLE         = 4'd0;
    localparam logic [3:0] PH_READ_CONTROL = 4'd1;
    localparam logic [3:0] PH_READ_ISTAT   = 4'd2;
    localparam logic [3:0] PH_TAKE_BUS     = 4'd3;
    localparam logic [3:0] PH_OWN_BUS      = 4'd4;
    localparam logic [3:0] PH_FORCE_BUS    = 4'd5;
    localparam logic [3:0] PH_REQUEST_BUS  = 4'd6;
    localparam logic [3:0] PH_WAITING      = 4'd7;
    localparam logic [3:0] PH_REL_READ     = 4'd8;
    localparam logic [3:0] PH_REL_WRITE    = 4'd9;

    typedef struct packed {
        logic [TICK_W-1:0] force_after;
        logic [TICK_W-1:0] give_up_after;
        logic [TICK_W-1:0] short_retry;
        logic [TICK_W-1:0] long_retry;
    } cfg_t;

    typedef struct packed {
        logic [3:0]        phase;
        logic [7:0]        saved_control;
        logic [TICK_W-1:0] elapsed;
        logic [TICK_W-1:0] wait_left;
    } seq_state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       bus_error;
    } event_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] action;
        logic [1:0] reg_addr;
        logic [7:0] write_value;
        logic [1:0] status;
    } result_t;

    // control value that turns the bus on, indexed by the low nibble of control
    function automatic logic [7:0] ctl_on(input logic [3:0] idx);
        logic [2:0] v;
        unique case (idx)
            4'd0:    v = 3'd4;
            4'd1:    v = 3'd0;
            4'd2:    v = 3'd1;
            4'd3:    v = 3'd5;
            4'd4:    v = 3'd4;
            4'd5:    v = 3'd4;
            4'd6:    v = 3'd5;
            4'd7:    v = 3'd5;
            4'd8:    v = 3'd0;
            4'd9:    v = 3'd0;
            4'd10:   v = 3'd1;
            4'd11:   v = 3'd1;
            4'd12:   v = 3'd0;
            4'd13:   v = 3'd4;
            4'd14:   v = 3'd5;
            default: v = 3'd1;
        endcase
        return {5'd0, v};
    endfunction

endpackage

// ===== rtl/tmbas_step.sv =====
// next-state and result logic for one event of the arbitration sequencer
module tmbas_step (
    input  tmbas_pkg::cfg_t       cfg,
    input  tmbas_pkg::seq_state_t cur,
    input  tmbas_pkg::event_t     ev,
    output tmbas_pkg::seq_state_t nxt,
    output tmbas_pkg::result_t    res
);
    import tmbas_pkg::*;

    logic              idle;
    logic              forced;
    logic              off;
    logic              mine;
    logic [7:0]        r;
    logic [TICK_W:0]   dbl_wide;
    logic [TICK_W-1:0] dbl;
    logic [TICK_W-1:0] elapsed_inc;

    assign r      = ev.data_byte;
    assign idle   = (cur.phase == PH_IDLE) || (cur.phase > PH_REL_WRITE);
    assign forced = cur.elapsed >= cfg.force_after;
    assign off    = (r[3:2] == 2'b00) || (r[3:2] == 2'b11);
    assign mine   = (r[1:0] == 2'b00) || (r[1:0] == 2'b11);

    assign dbl_wide    = {cfg.long_retry, 1'b0};
    assign dbl         = dbl_wide[TICK_W] ? TICK_MAX : dbl_wide[TICK_W-1:0];
    assign elapsed_inc = (cur.elapsed == TICK_MAX) ? cur.elapsed : cur.elapsed + 24'd1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (ev.command)
            CMD_ACQUIRE:
            begin
                if (idle)
                begin
                    nxt.elapsed   = '0;
                    nxt.wait_left = '0;
                    nxt.phase     = PH_READ_CONTROL;
                    res.valid     = 1'b1;
                    res.action    = ACT_READ;
                    res.reg_addr  = REG_CONTROL;
                end
            end
            CMD_RELEASE:
            begin
                if (idle)
                begin
                    nxt.phase    = PH_REL_READ;
                    res.valid    = 1'b1;
                    res.action   = ACT_READ;
                    res.reg_addr = REG_CONTROL;
                end
            end
            CMD_COMPLETE:
            begin
                if (!idle && cur.phase != PH_WAITING)
                begin
                    if (ev.bus_error)
                    begin
                        nxt.phase  = PH_IDLE;
                        res.valid  = 1'b1;
                        res.action = ACT_DONE;
                        res.status = ST_XFER;
                    end
                    else
                    begin
                        unique case (cur.phase)
                            PH_READ_CONTROL:
                            begin
                                priority if (off)
                                begin
                                    nxt.phase         = PH_READ_ISTAT;
                                    nxt.saved_control = r;
                                    res.valid         = 1'b1;
                                    res.action        = ACT_READ;
                                    res.reg_addr      = REG_ISTAT;
                                end
                                else if (mine)
                                begin
                                    nxt.phase       = PH_OWN_BUS;
                                    res.valid       = 1'b1;
                                    res.action      = ACT_WRITE;
                                    res.reg_addr    = REG_CONTROL;
                                    res.write_value = r & ~(CTL_NTESTON | CTL_BUSINIT);
                                end
                                else if (forced)
                                begin
                                    nxt.phase       = PH_FORCE_BUS;
                                    res.valid       = 1'b1;
                                    res.action      = ACT_WRITE;
                                    res.reg_addr    = REG_CONTROL;
                                    res.write_value = ctl_on(r[3:0]) | CTL_BUSINIT
                                                      | CTL_NTESTON;
                                end
                                else if (r[7] == 1'b0)
                                begin
                                    nxt.phase       = PH_REQUEST_BUS;
                                    res.valid       = 1'b1;
                                    res.action      = ACT_WRITE;
                                    res.reg_addr    = REG_CONTROL;
                                    res.write_value = r | CTL_NTESTON;
                                end
                                else
                                begin
                                    nxt.phase     = PH_WAITING;
                                    nxt.wait_left = cfg.long_retry;
                                end
                            end
                            PH_READ_ISTAT:
                            begin
                                if (!r[7] || forced)
                                begin
                                    nxt.phase       = PH_TAKE_BUS;
                                    res.valid       = 1'b1;
                                    res.action      = ACT_WRITE;
                                    res.reg_addr    = REG_CONTROL;
                                    res.write_value = ctl_on(cur.saved_control[3:0])
                                                      | CTL_NTESTON;
                                end
                                else
                                begin
                                    nxt.phase     = PH_WAITING;
                                    nxt.wait_left = dbl;
                                end
                            end
                            PH_TAKE_BUS:
                            begin
                                nxt.phase     = PH_WAITING;
                                nxt.wait_left = cfg.short_retry;
                            end
                            PH_FORCE_BUS, PH_REQUEST_BUS:
                            begin
                                nxt.phase     = PH_WAITING;
                                nxt.wait_left = cfg.long_retry;
                            end
                            PH_REL_READ:
                            begin
                                if (!off && mine)
                                begin
                                    nxt.phase       = PH_REL_WRITE;
                                    res.valid       = 1'b1;
                                    res.action      = ACT_WRITE;
                                    res.reg_addr    = REG_CONTROL;
                                    res.write_value = (r & CTL_NBUSON) >> 1;
                                end
                                else
                                begin
                                    nxt.phase  = PH_IDLE;
                                    res.valid  = 1'b1;
                                    res.action = ACT_DONE;
                                    res.status = ST_OK;
                                end
                            end
                            default:
                            begin
                                // own bus write or release write finished
                                nxt.phase  = PH_IDLE;
                                res.valid  = 1'b1;
                                res.action = ACT_DONE;
                                res.status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                // time tick
                nxt.elapsed = elapsed_inc;
                if (cur.phase == PH_WAITING)
                begin
                    if (cur.wait_left > 24'd1)
                    begin
                        nxt.wait_left = cur.wait_left - 24'd1;
                    end
                    else
                    begin
                        nxt.wait_left = '0;
                        res.valid     = 1'b1;
                        if (elapsed_inc > cfg.give_up_after)
                        begin
                            nxt.phase  = PH_IDLE;
                            res.action = ACT_DONE;
                            res.status = ST_TIMEOUT;
                        end
                        else
                        begin
                            nxt.phase    = PH_READ_CONTROL;
                            res.action   = ACT_READ;
                            res.reg_addr = REG_CONTROL;
                        end
                    end
                end
            end
        endcase
    end

endmodule

// ===== rtl/two_master_bus_arbitration_sequencer_top.sv =====
// Sequencer that acquires and releases a bus shared through a two-master selector.
//
// Input channel (in_valid/in_stall) carries one event per transaction: start
// acquire, start release, register access completed (data_byte, bus_error) or
// one time tick. Output channel (out_valid/out_stall) carries the next action:
// a register read, a control register write, or completion with a status.
// An event yields zero or one output transaction.
// An accepted event is held in the input register and evaluated from there, and
// its result is registered in the output register, which drives the output.
// Throughput: one event per cycle unless the output stalls; the state update of
// one event is a single registered step between the input and output registers.
// When the receiver stalls, the output register holds its transaction and the
// input register keeps one more event, after which in_stall goes high.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and are meant only while no event is in flight.
// Reset puts the phase in idle, clears the counters and saved control byte,
// loads the default tick limits and empties both registers.
module two_master_bus_arbitration_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        bus_error,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [1:0]  reg_addr,
    output logic [7:0]  write_value,
    output logic [1:0]  status
);
    import tmbas_pkg::*;

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       ev_valid_reg;
    event_t     ev_reg;
    result_t    res_next;
    logic       out_valid_reg;
    logic [1:0] action_reg;
    logic [1:0] reg_addr_reg;
    logic [7:0] write_value_reg;
    logic [1:0] status_reg;
    logic       out_free;
    logic       advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = ev_valid_reg && out_free;
    assign in_stall = ev_valid_reg && !out_free;

    tmbas_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .ev  (ev_reg),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_after   <= FORCE_AFTER_RST;
            cfg_reg.give_up_after <= GIVE_UP_AFTER_RST;
            cfg_reg.short_retry   <= SHORT_RETRY_RST;
            cfg_reg.long_retry    <= LONG_RETRY_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FORCE_AFTER:   cfg_reg.force_after   <= cfg_data;
                CFG_GIVE_UP_AFTER: cfg_reg.give_up_after <= cfg_data;
                CFG_SHORT_RETRY:   cfg_reg.short_retry   <= cfg_data;
                default:           cfg_reg.long_retry    <= cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            ev_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            ev_reg.command   <= command;
            ev_reg.data_byte <= data_byte;
            ev_reg.bus_error <= bus_error;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, saved_control: '0, elapsed: '0, wait_left: '0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && res_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_next.valid)
        begin
            action_reg      <= res_next.action;
            reg_addr_reg    <= res_next.reg_addr;
            write_value_reg <= res_next.write_value;
            status_reg      <= res_next.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign reg_addr    = reg_addr_reg;
    assign write_value = write_value_reg;
    assign status      = status_reg;

endmodule

// ===== rtl/tmbas_check.sv =====
// port-level checks of the arbitration sequencer and their binding to the top level
module tmbas_check (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] action,
    input logic [1:0] reg_addr,
    input logic [7:0] write_value,
    input logic [1:0] status
);
    import tmbas_pkg::*;

    // a stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action) && $stable(reg_addr)
            && $stable(write_value) && $stable(status))
        else $error("stalled output transaction changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_READ |->
            (reg_addr == REG_CONTROL || reg_addr == REG_ISTAT)
            && write_value == 8'd0 && status == ST_OK)
        else $error("malformed read request");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_WRITE |-> reg_addr == REG_CONTROL && status == ST_OK)
        else $error("malformed control write");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_DONE |->
            reg_addr == REG_NONE && write_value == 8'd0
            && (status == ST_OK || status == ST_TIMEOUT || status == ST_XFER))
        else $error("malformed completion");

endmodule

bind two_master_bus_arbitration_sequencer_top tmbas_check u_tmbas_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .reg_addr    (reg_addr),
    .write_value (write_value),
    .status      (status)
);
